@@ rtl/pmct_pkg.sv @@
// Package with the constants, types and helper functions of the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps

package pmct_pkg;

  // Screen grid and start position.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int START_COLUMN   = 40;
  localparam int START_ROW      = 12;

  // Field widths.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 11;
  localparam int BTN_W  = 3;
  localparam int SUM_W  = 10;

  // Reset values of the cursor, cut to the field widths.
  localparam logic [COL_W-1:0] START_COL_CODE = COL_W'(START_COLUMN);
  localparam logic [ROW_W-1:0] START_ROW_CODE = ROW_W'(START_ROW);

  // Position of the next byte inside a three-byte packet.
  typedef enum logic [1:0] {
    POS_BYTE0 = 2'd0,
    POS_BYTE1 = 2'd1,
    POS_BYTE2 = 2'd2
  } pos_t;

  // Completed packet handed from the assembler to the cursor unit.
  typedef struct packed {
    logic             complete;
    logic [BTN_W-1:0] button_bits;
    logic [7:0]       dx;
    logic [7:0]       dy;
  } pkt_t;

  // One result word.
  typedef struct packed {
    logic [CELL_W-1:0] old_cell_index;
    logic [CELL_W-1:0] new_cell_index;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [BTN_W-1:0]  button_bits;
  } res_t;

  // Clamp a signed coordinate into 0 .. limit-1.
  function automatic logic [7:0] clamp_axis(input logic signed [SUM_W-1:0] v,
                                            input logic [7:0] limit);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v >= $signed({2'b00, limit})) begin
      r = limit - 8'd1;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Text cell index row*SCREEN_COLUMNS + col, cut to the field width.
  function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    logic [12:0] p;
    p = 13'(r) * 13'(SCREEN_COLUMNS) + 13'(c);
    return p[CELL_W-1:0];
  endfunction

endpackage

@@ rtl/pmct_ifs.sv @@
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface pmct_in_if;
  logic       valid;
  logic       ready;
  logic       data_ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_ready, output data_byte, input ready);
  modport sink (input valid, input data_ready, input data_byte, output ready);
endinterface

interface pmct_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] old_cell_index;
  logic [10:0] new_cell_index;
  logic [6:0]  column;
  logic [4:0]  row;
  logic [2:0]  button_bits;

  modport source (output valid, output old_cell_index, output new_cell_index,
                  output column, output row, output button_bits, input ready);
  modport sink (input valid, input old_cell_index, input new_cell_index,
                input column, input row, input button_bits, output ready);
endinterface

@@ rtl/pmct_packet_asm.sv @@
// Packet assembler: counts bytes modulo three and keeps bytes zero and one.
`timescale 1ns / 1ps

module pmct_packet_asm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     byte_in,
  output pmct_pkg::pkt_t pkt
);
  import pmct_pkg::*;

  pos_t       pos_r;
  pos_t       pos_nxt;
  logic [7:0] byte0_r;
  logic [7:0] byte1_r;
  logic       last_byte;

  // Next byte position.
  always_comb begin
    pos_nxt = pos_r;
    if (step) begin
      case (pos_r)
        POS_BYTE0: pos_nxt = POS_BYTE1;
        POS_BYTE1: pos_nxt = POS_BYTE2;
        default:   pos_nxt = POS_BYTE0;
      endcase
    end
  end

  // The third byte, and the unused code too, closes a packet.
  always_comb begin
    case (pos_r)
      POS_BYTE0: last_byte = 1'b0;
      POS_BYTE1: last_byte = 1'b0;
      default:   last_byte = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_BYTE0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Packet bytes zero and one.
  always_ff @(posedge clk) begin
    if (step && pos_r == POS_BYTE0) begin
      byte0_r <= byte_in;
    end
    if (step && pos_r == POS_BYTE1) begin
      byte1_r <= byte_in;
    end
  end

  assign pkt.complete    = step && last_byte;
  assign pkt.button_bits = byte0_r[BTN_W-1:0];
  assign pkt.dx          = byte1_r;
  assign pkt.dy          = byte_in;

endmodule

@@ rtl/pmct_cursor.sv @@
// Cursor unit: holds the cursor, applies a packet's deltas and clamps to the grid.
`timescale 1ns / 1ps

module pmct_cursor (
  input  logic           clk,
  input  logic           rst_n,
  input  pmct_pkg::pkt_t pkt,
  output pmct_pkg::res_t res
);
  import pmct_pkg::*;

  logic [COL_W-1:0]        cursor_col_r;
  logic [ROW_W-1:0]        cursor_row_r;
  logic [COL_W-1:0]        cursor_col_nxt;
  logic [ROW_W-1:0]        cursor_row_nxt;
  logic signed [SUM_W-1:0] col_sum;
  logic signed [SUM_W-1:0] row_sum;
  logic [7:0]              col_clamped;
  logic [7:0]              row_clamped;

  // Wide signed add of X and subtract of Y, so no 8-bit wrap occurs.
  assign col_sum = $signed({3'b000, cursor_col_r}) + $signed({{2{pkt.dx[7]}}, pkt.dx});
  assign row_sum = $signed({5'b00000, cursor_row_r}) - $signed({{2{pkt.dy[7]}}, pkt.dy});

  assign col_clamped    = clamp_axis(col_sum, 8'(SCREEN_COLUMNS));
  assign row_clamped    = clamp_axis(row_sum, 8'(SCREEN_ROWS));
  assign cursor_col_nxt = col_clamped[COL_W-1:0];
  assign cursor_row_nxt = row_clamped[ROW_W-1:0];

  // The cursor moves only when a packet completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= START_COL_CODE;
      cursor_row_r <= START_ROW_CODE;
    end else if (pkt.complete) begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  // Result word for the packet.
  assign res.old_cell_index = cell_of(cursor_row_r, cursor_col_r);
  assign res.new_cell_index = cell_of(cursor_row_nxt, cursor_col_nxt);
  assign res.column         = cursor_col_nxt;
  assign res.row            = cursor_row_nxt;
  assign res.button_bits    = pkt.button_bits;

endmodule

@@ rtl/ps2_mouse_cursor_tracker.sv @@
// Top level of the PS/2 mouse cursor tracker: input register, packet logic, result register.
`timescale 1ns / 1ps

// One byte event enters per cycle while in_ch.ready is high. An event with
// data_ready clear is taken and dropped. Each third accepted byte closes a
// packet and yields one result word; the byte waits in the input register,
// the word in the result register. The cursor register's next value (add,
// clamp and cell index) is formed combinationally. While a result waits at
// the output, one more byte can still be taken into the input register.
module ps2_mouse_cursor_tracker (
  input logic        clk,
  input logic        rst_n,
  pmct_in_if.sink    in_ch,
  pmct_out_if.source out_ch
);
  import pmct_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       advance;
  logic       step;
  pkt_t       pkt;
  res_t       res;
  logic       out_valid_r;
  res_t       out_r;

  // The stage moves when the result register is free or being emptied.
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  // Input register: only words with data_ready set are kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid && in_ch.data_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
    end
  end

  pmct_packet_asm u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (s1_byte_r),
    .pkt     (pkt)
  );

  pmct_cursor u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .pkt   (pkt),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= pkt.complete;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.complete) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.old_cell_index = out_r.old_cell_index;
  assign out_ch.new_cell_index = out_r.new_cell_index;
  assign out_ch.column         = out_r.column;
  assign out_ch.row            = out_r.row;
  assign out_ch.button_bits    = out_r.button_bits;

  // A shown cursor position always lies on the grid.
  a_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_r.column) < SCREEN_COLUMNS) && (32'(out_r.row) < SCREEN_ROWS))
    else $error("cursor position off the grid");

  // The new cell index agrees with the shown position.
  a_cell_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.new_cell_index == cell_of(out_r.row, out_r.column))
    else $error("new cell index does not match position");

  // Input is held off only while a byte waits behind a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without cause");

  // A packet cannot complete while its result would overwrite a waiting one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    pkt.complete |-> advance)
    else $error("result overwritten");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the PS/2 mouse cursor tracker, with a cursor predictor.
`timescale 1ns / 1ps

module tb;
  import pmct_pkg::*;

  localparam int RANDOM_BYTES = 1400;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 10;
  localparam int DIR_ROWS     = 24;
  localparam longint LIMIT_NS = 64'd4_000_000;

  // One word offered on the byte channel, with an optional hand-typed result.
  typedef struct {
    logic       dr;
    logic [7:0] b;
    logic       typed;
    res_t       want;
  } stim_t;

  logic clk;
  logic rst_n;

  pmct_in_if  in_ch ();
  pmct_out_if out_ch ();

  ps2_mouse_cursor_tracker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: packet assembly and cursor position.
  int         pkt_pos;
  logic [7:0] pkt_bytes [2];
  logic [6:0] cur_col;
  logic [4:0] cur_row;

  res_t pending_moves [$];
  stim_t send_list [$];
  stim_t directed_rows [DIR_ROWS];

  // Side information for the word currently on the byte channel.
  logic drv_typed;
  res_t drv_want;

  int  bytes_taken;
  int  bytes_ignored;
  int  moves_checked;
  int  errors;
  int  results_seen;
  bit  hold_on;
  bit  stim_done;

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [10:0] text_cell(input int r, input int c);
    int p;
    p = r * SCREEN_COLUMNS + c;
    return p[10:0];
  endfunction

  // Feed one accepted data byte; returns 1 when it closes a packet and fills mv.
  function automatic bit advance_cursor(input logic [7:0] b, output res_t mv);
    int ncol;
    int nrow;
    mv = '0;
    if (pkt_pos < 2) begin
      pkt_bytes[pkt_pos] = b;
      pkt_pos++;
      return 1'b0;
    end
    pkt_pos = 0;
    mv.old_cell_index = text_cell(int'(cur_row), int'(cur_col));
    // Deltas are applied at full integer width, then clamped to the grid.
    ncol = int'(cur_col) + int'($signed(pkt_bytes[1]));
    nrow = int'(cur_row) - int'($signed(b));
    if (ncol < 0) ncol = 0;
    else if (ncol >= SCREEN_COLUMNS) ncol = SCREEN_COLUMNS - 1;
    if (nrow < 0) nrow = 0;
    else if (nrow >= SCREEN_ROWS) nrow = SCREEN_ROWS - 1;
    cur_col = ncol[6:0];
    cur_row = nrow[4:0];
    mv.new_cell_index = text_cell(int'(cur_row), int'(cur_col));
    mv.column = cur_col;
    mv.row = cur_row;
    mv.button_bits = pkt_bytes[0][2:0];
    return 1'b1;
  endfunction

  function automatic res_t move_word(input int o, input int n, input int c, input int r,
                                     input int btn);
    res_t m;
    m.old_cell_index = o[10:0];
    m.new_cell_index = n[10:0];
    m.column = c[6:0];
    m.row = r[4:0];
    m.button_bits = btn[2:0];
    return m;
  endfunction

  function automatic stim_t word(input logic dr, input logic [7:0] b);
    stim_t s;
    s.dr = dr;
    s.b = b;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_t closing(input logic [7:0] b, input res_t want);
    stim_t s;
    s.dr = 1'b1;
    s.b = b;
    s.typed = 1'b1;
    s.want = want;
    return s;
  endfunction

  // Motion byte: small moves and full-range values, with the two extremes mixed in.
  function automatic logic [7:0] delta_byte();
    int pick;
    logic [7:0] d;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        d = 8'h7F;
      end
      1: begin
        d = 8'h80;
      end
      2, 3, 4, 5: begin
        d = 8'($urandom_range(0, 16) - 8);
      end
      default: begin
        d = 8'($urandom);
      end
    endcase
    return d;
  endfunction

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Reset, then wait for the stimulus to finish and every cursor move to arrive.
  initial begin
    rst_n = 1'b0;
    pkt_pos = 0;
    pkt_bytes[0] = '0;
    pkt_bytes[1] = '0;
    cur_col = START_COL_CODE;
    cur_row = START_ROW_CODE;
    bytes_taken = 0;
    bytes_ignored = 0;
    moves_checked = 0;
    errors = 0;
    results_seen = 0;
    hold_on = 1'b0;
    stim_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d data bytes and %0d ignored events, directed and random.",
             bytes_taken, bytes_ignored);
    $display("%0d cursor moves checked, with a %0d-cycle output hold-off along the way.",
             moves_checked, LONG_HOLD);
    if (errors == 0) begin
      $display("ps2_mouse_cursor_tracker test passed");
    end else begin
      $display("ps2_mouse_cursor_tracker test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("ps2_mouse_cursor_tracker test failed");
    $finish;
  end

  // Byte sender: directed rows first, then random packets, offered in bursts.
  initial begin
    int taken;
    int pick;
    int len;
    int idx;
    int burst;
    int gap;
    in_ch.valid = 1'b0;
    in_ch.data_ready = 1'b0;
    in_ch.data_byte = 8'h00;
    drv_typed = 1'b0;
    drv_want = '0;

    // Directed rows: ignored events, extremes of both deltas, clamps at every edge.
    directed_rows = '{
      word(1'b0, 8'hFF),
      word(1'b1, 8'h08),
      word(1'b1, 8'h00),
      closing(8'h00, move_word(1000, 1000, 40, 12, 0)),
      word(1'b0, 8'h55),
      word(1'b1, 8'hFF),
      word(1'b0, 8'h00),
      word(1'b1, 8'h7F),
      closing(8'h80, move_word(1000, 1999, 79, 24, 7)),
      word(1'b1, 8'h01),
      word(1'b1, 8'h80),
      closing(8'h7F, move_word(1999, 0, 0, 0, 1)),
      word(1'b1, 8'h02),
      word(1'b1, 8'h01),
      closing(8'hFF, move_word(0, 81, 1, 1, 2)),
      word(1'b1, 8'h04),
      word(1'b1, 8'hFF),
      closing(8'h01, move_word(81, 0, 0, 0, 4)),
      word(1'b1, 8'h03),
      word(1'b1, 8'h4F),
      closing(8'hE8, move_word(0, 1999, 79, 24, 3)),
      word(1'b1, 8'h05),
      word(1'b1, 8'hF0),
      word(1'b1, 8'h10)
    };
    taken = 0;
    foreach (directed_rows[i]) begin
      send_list.push_back(directed_rows[i]);
      if (directed_rows[i].dr) taken++;
    end

    // Random packets with stray ignored events and the odd broken fragment.
    while (taken < RANDOM_BYTES) begin
      pick = $urandom_range(0, 39);
      len = (pick == 0) ? $urandom_range(1, 2) : 3;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) send_list.push_back(word(1'b0, 8'($urandom)));
        send_list.push_back(word(1'b1, (k == 0) ? 8'($urandom) : delta_byte()));
        taken++;
      end
    end

    do @(posedge clk); while (!rst_n);
    idx = 0;
    while (idx < send_list.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < send_list.size()) begin
        in_ch.valid <= 1'b1;
        in_ch.data_ready <= send_list[idx].dr;
        in_ch.data_byte <= send_list[idx].b;
        drv_typed <= send_list[idx].typed;
        drv_want <= send_list[idx].want;
        do @(posedge clk); while (!in_ch.ready);
        idx++;
        burst--;
      end
      // No gaps while the receiver holds off, so the block backs up.
      gap = (hold_on || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 || idx == send_list.size()) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (idx > 0) @(posedge clk);
    stim_done = 1'b1;
  end

  // Result receiver: stall patterns that change every stretch, plus one long hold-off.
  initial begin
    int mode;
    int span;
    int cyc;
    bit held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    cyc = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        if (!held && results_seen >= 30) begin
          held = 1'b1;
          hold_on = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_on = 1'b0;
        end else begin
          case (mode)
            0: begin
              out_ch.ready <= 1'b1;
            end
            1: begin
              out_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
              out_ch.ready <= (cyc % 4 == 0);
            end
            default: begin
              out_ch.ready <= ($urandom_range(0, 7) != 0);
            end
          endcase
          cyc++;
          @(posedge clk);
        end
      end
    end
  end

  // Handshake monitor: predict on accepted bytes, check accepted results in order.
  always @(posedge clk) begin : track
    res_t pred;
    res_t got;
    res_t want;
    bit   made;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.old_cell_index = out_ch.old_cell_index;
        got.new_cell_index = out_ch.new_cell_index;
        got.column = out_ch.column;
        got.row = out_ch.row;
        got.button_bits = out_ch.button_bits;
        if (pending_moves.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = pending_moves.pop_front();
          cmp_field("old_cell_index", want.old_cell_index, got.old_cell_index);
          cmp_field("new_cell_index", want.new_cell_index, got.new_cell_index);
          cmp_field("column", want.column, got.column);
          cmp_field("row", want.row, got.row);
          cmp_field("button_bits", want.button_bits, got.button_bits);
          moves_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (!in_ch.data_ready) begin
          bytes_ignored++;
        end else begin
          bytes_taken++;
          made = advance_cursor(in_ch.data_byte, pred);
          if (made) pending_moves.push_back(drv_typed ? drv_want : pred);
        end
      end
    end
  end

endmodule
